// ----- design/nvlp_pkg.sv -----
// ----------------------------------------------------------------------------
// nvlp_pkg
// Shared types and constants for the name/value list parser.
// ----------------------------------------------------------------------------
package nvlp_pkg;

  localparam int unsigned SpaceCntW     = 16;
  localparam logic [SpaceCntW-1:0] SpaceCountMax = 16'hFFFF;

  localparam logic [2:0] EvNameChar  = 3'd0;
  localparam logic [2:0] EvValueChar = 3'd1;
  localparam logic [2:0] EvNameDone  = 3'd2;
  localparam logic [2:0] EvEntryDone = 3'd3;
  localparam logic [2:0] EvError     = 3'd4;

  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrEmptyName  = 2'd1;
  localparam logic [1:0] ErrEmptyValue = 2'd2;

  localparam logic KindChar = 1'b0;
  localparam logic KindEol  = 1'b1;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChColon = 8'h3A;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [7:0]           out_char;
    logic [SpaceCntW-1:0] spaces_before;
    logic                 has_value;
    logic [1:0]           error_code;
    logic                 line_done;
  } result_t;

endpackage

// ----- design/nvlp_in_reg.sv -----
// ----------------------------------------------------------------------------
// nvlp_in_reg
// Input register: holds one accepted transaction until the parser takes it.
// ----------------------------------------------------------------------------
module nvlp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nvlp_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output nvlp_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  nvlp_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/nvlp_core.sv -----
// ----------------------------------------------------------------------------
// nvlp_core
// Parser state and per-character step logic.
// ----------------------------------------------------------------------------
module nvlp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  nvlp_pkg::item_t   item_i,
  output logic              res_valid_o,
  output nvlp_pkg::result_t res_o
);

  logic                           in_value_q, in_value_d;
  logic                           started_q, started_d;
  logic [nvlp_pkg::SpaceCntW-1:0] held_q, held_d;
  logic                           skip_q, skip_d;
  logic                           is_blank, is_eol_char, is_sep;
  nvlp_pkg::result_t              res;
  logic                           res_valid;

  assign is_blank    = (item_i.ch == nvlp_pkg::ChSpace) || (item_i.ch == nvlp_pkg::ChTab) ||
                       (item_i.ch == nvlp_pkg::ChVt) || (item_i.ch == nvlp_pkg::ChFf);
  assign is_eol_char = (item_i.ch == nvlp_pkg::ChCr) || (item_i.ch == nvlp_pkg::ChLf) ||
                       (item_i.ch == nvlp_pkg::ChNul);
  assign is_sep      = (item_i.ch == nvlp_pkg::ChComma) ||
                       ((item_i.ch == nvlp_pkg::ChColon) && !in_value_q);

  always_comb begin
    in_value_d = in_value_q;
    started_d  = started_q;
    held_d     = held_q;
    skip_d     = skip_q;
    res        = '0;
    res_valid  = 1'b0;
    if ((item_i.kind == nvlp_pkg::KindEol) && skip_q) begin
      in_value_d = 1'b0;
      started_d  = 1'b0;
      held_d     = '0;
      skip_d     = 1'b0;
    end else if (skip_q) begin
      res_valid = 1'b0;
    end else if ((item_i.kind == nvlp_pkg::KindEol) || is_eol_char ||
                 (is_sep && !started_q)) begin
      // line ends here: entry done or empty-field error
      res_valid      = 1'b1;
      res.line_done  = 1'b1;
      if (!started_q) begin
        res.event_res  = nvlp_pkg::EvError;
        res.error_code = in_value_q ? nvlp_pkg::ErrEmptyValue : nvlp_pkg::ErrEmptyName;
      end else begin
        res.event_res  = nvlp_pkg::EvEntryDone;
        res.has_value  = in_value_q;
      end
      in_value_d = 1'b0;
      started_d  = 1'b0;
      held_d     = '0;
      skip_d     = (item_i.kind == nvlp_pkg::KindChar);
    end else if (is_blank) begin
      if (started_q && (held_q != nvlp_pkg::SpaceCountMax)) begin
        held_d = held_q + 1'b1;
      end
    end else if (is_sep) begin
      res_valid = 1'b1;
      if (item_i.ch == nvlp_pkg::ChColon) begin
        res.event_res = nvlp_pkg::EvNameDone;
        in_value_d    = 1'b1;
      end else begin
        res.event_res = nvlp_pkg::EvEntryDone;
        res.has_value = in_value_q;
        in_value_d    = 1'b0;
      end
      started_d = 1'b0;
      held_d    = '0;
    end else begin
      res_valid         = 1'b1;
      res.event_res     = in_value_q ? nvlp_pkg::EvValueChar : nvlp_pkg::EvNameChar;
      res.out_char      = item_i.ch;
      res.spaces_before = started_q ? held_q : '0;
      started_d         = 1'b1;
      held_d            = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      started_q  <= 1'b0;
      held_q     <= '0;
      skip_q     <= 1'b0;
    end else if (step_i) begin
      in_value_q <= in_value_d;
      started_q  <= started_d;
      held_q     <= held_d;
      skip_q     <= skip_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> (!in_value_q && !started_q && (held_q == '0)))
    else $error("skip state with live field state");

  a_held_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (held_q == '0))
    else $error("held spaces without a started field");

  a_line_done_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid && res.line_done) |=> (!in_value_q && !started_q))
    else $error("field state not cleared after line end");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(in_value_q) && $stable(held_q) && $stable(skip_q)))
    else $error("parser state changed without a step");

endmodule

// ----- design/nvlp_out_reg.sv -----
// ----------------------------------------------------------------------------
// nvlp_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module nvlp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  nvlp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nvlp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  nvlp_pkg::result_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/name_value_list_parser_unit.sv -----
// ----------------------------------------------------------------------------
// name_value_list_parser_unit
// Streaming parser for one "name[:value], ..." line, one character a cycle while the sink keeps up.
// ----------------------------------------------------------------------------
// Each input transaction is one character or an end-of-line marker. It is
// registered in the input register, processed by the combinational parser
// step logic, and at most one result transaction is written to the output
// register, which holds it until the sink takes it. Throughput is one input
// transaction per cycle while the sink keeps up. Characters that produce no
// result (white space, characters after the line has ended) move on even
// while a result waits at the output.
module name_value_list_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  out_char_o,
  output logic [15:0] spaces_before_o,
  output logic        has_value_o,
  output logic [1:0]  error_code_o,
  output logic        line_done_o
);

  nvlp_pkg::item_t   in_item, reg_item;
  nvlp_pkg::result_t core_res, out_res;
  logic              reg_valid, core_res_valid, out_free, advance;

  assign in_item.kind = kind_i;
  assign in_item.ch   = ch_i;
  assign advance      = reg_valid && (out_free || !core_res_valid);

  nvlp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (reg_valid),
    .item_o     (reg_item)
  );

  nvlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (reg_item),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  nvlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && core_res_valid),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign event_res_o     = out_res.event_res;
  assign out_char_o      = out_res.out_char;
  assign spaces_before_o = out_res.spaces_before;
  assign has_value_o     = out_res.has_value;
  assign error_code_o    = out_res.error_code;
  assign line_done_o     = out_res.line_done;

endmodule
